/* rtl/brr_pkg.sv */
// ----------------------------------------------------------------------------
// brr_pkg
// Shared widths and sequencer state codes for the bounded rational reducer.
// ----------------------------------------------------------------------------
package brr_pkg;

    localparam int IN_W    = 64;              // input term width
    localparam int TERM_W  = 31;              // bounded term width
    localparam int ACC_W   = 96;              // 64 x 32 product width
    localparam int MULT_W  = 32;              // multiplier operand width
    localparam int CNT_W   = 7;               // holds IN_W
    localparam int S_DATA_W = 2 * IN_W;
    localparam int M_DATA_W = 64;             // 32 + 31 bits, byte padded

    localparam logic [TERM_W-1:0] MAX_TERM_RST = {TERM_W{1'b1}};

    typedef enum logic [17:0] {
        S_IDLE = 18'h00001,
        S_GCD  = 18'h00002,
        S_GCDW = 18'h00004,
        S_DIVN = 18'h00008,
        S_DIVD = 18'h00010,
        S_CHK  = 18'h00020,
        S_LOOP = 18'h00040,
        S_LX   = 18'h00080,
        S_LN0  = 18'h00100,
        S_LN1  = 18'h00200,
        S_LD0  = 18'h00400,
        S_LD1  = 18'h00800,
        S_SEL  = 18'h01000,
        S_M1W  = 18'h02000,
        S_M2W  = 18'h04000,
        S_M3W  = 18'h08000,
        S_M4W  = 18'h10000,
        S_OUT  = 18'h20000
    } t_state;

    // start request to the shared shift/add unit
    typedef struct packed {
        logic            start;
        logic            mul;    // 1: a * b[31:0], 0: a / b
        logic [IN_W-1:0] a;
        logic [IN_W-1:0] b;
    } t_unit_req;

endpackage

/* rtl/bounded_rational_reduce_top.sv */
// ----------------------------------------------------------------------------
// bounded_rational_reduce_top
// Reduces a signed 64-bit fraction by its gcd and, when a term exceeds
// max_term, replaces it by the best continued-fraction approximation.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid / tready           tdata: in_num[63:0], in_den[127:64]
//  m_axis    out  tvalid / tready           tdata: out_num[31:0], out_den[62:32]
//                                           tuser: exact
//  cfg       in   we (no handshake back)    wdata: max_term
//
//  One request at a time. A single shift/add unit does all divisions and
//  multiplies. Each Euclid round of the gcd is one division; each convergent
//  round is one quotient, two limit divisions and two multiplies, plus two
//  wide multiplies for the final semiconvergent check. The time for one
//  request is set by the Euclid rounds (up to about 92 for 64-bit terms)
//  and the convergent rounds (up to about 45 at the widest limit).
//  Reset (synchronous, active low) returns to idle and sets max_term to
//  its maximum. The result waits in the output register; a new request is
//  taken while it waits, and the block holds before delivering the next one.
// ----------------------------------------------------------------------------
module bounded_rational_reduce_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [brr_pkg::TERM_W-1:0]    i_cfg_wdata,      // max_term
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [brr_pkg::S_DATA_W-1:0]  i_s_axis_tdata,   // in_num, in_den
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [brr_pkg::M_DATA_W-1:0]  o_m_axis_tdata,   // out_num, out_den, pad
    output logic                          o_m_axis_tuser    // exact
);
    import brr_pkg::*;

    // ---------------- configuration ----------------
    logic [TERM_W-1:0] r_maxt;
    logic [TERM_W-1:0] lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maxt <= MAX_TERM_RST;
        end else if (i_cfg_we) begin
            r_maxt <= i_cfg_wdata;
        end
    end

    // a zero limit acts as one
    assign lim = (r_maxt == '0) ? TERM_W'(1) : r_maxt;

    // ---------------- shared shift/add unit ----------------
    // Division: restoring, one quotient bit per cycle, r_uq shifts the
    // dividend out and the quotient in. Multiply: MSB-first shift-add with
    // the multiplier in r_uq[63:32].
    t_unit_req           req;
    logic                r_run;
    logic                r_umul;
    logic [CNT_W-1:0]    r_ucnt;
    logic [IN_W-1:0]     r_ua;
    logic [IN_W-1:0]     r_ub;
    logic [IN_W-1:0]     r_uq;
    logic [IN_W-1:0]     r_ur;
    logic [ACC_W-1:0]    r_acc;
    logic [IN_W:0]       rem_sh;
    logic [IN_W:0]       diff;
    logic [ACC_W-1:0]    acc_nx;

    always_comb begin
        rem_sh = {r_ur, r_uq[IN_W-1]};
        diff   = rem_sh - {1'b0, r_ub};
        acc_nx = {r_acc[ACC_W-2:0], 1'b0}
               + (r_uq[IN_W-1] ? {{(ACC_W-IN_W){1'b0}}, r_ua} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_ucnt <= '0;
        end else if (req.start) begin
            r_run  <= 1'b1;
            r_ucnt <= req.mul ? CNT_W'(MULT_W) : CNT_W'(IN_W);
        end else if (r_run) begin
            r_ucnt <= r_ucnt - CNT_W'(1);
            if (r_ucnt == CNT_W'(1)) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req.start) begin
            r_umul <= req.mul;
            r_ua   <= req.a;
            r_ub   <= req.b;
            r_ur   <= '0;
            r_acc  <= '0;
            r_uq   <= req.mul ? {req.b[MULT_W-1:0], {(IN_W-MULT_W){1'b0}}} : req.a;
        end else if (r_run) begin
            if (r_umul) begin
                r_acc <= acc_nx;
                r_uq  <= {r_uq[IN_W-2:0], 1'b0};
            end else begin
                r_ur  <= diff[IN_W] ? rem_sh[IN_W-1:0] : diff[IN_W-1:0];
                r_uq  <= {r_uq[IN_W-2:0], ~diff[IN_W]};
            end
        end
    end

    // ---------------- sequencer ----------------
    t_state             r_state, n_state;
    logic [IN_W-1:0]    r_num, n_num, r_den, n_den;    // reduced terms / CF remainders
    logic [IN_W-1:0]    r_ea, n_ea, r_eb, n_eb;        // Euclid pair
    logic [IN_W-1:0]    r_x, n_x, r_rem, n_rem;        // partial quotient, remainder
    logic [TERM_W-1:0]  r_limn, n_limn, r_limd, n_limd;
    logic               r_ninf, n_ninf, r_dinf, n_dinf;
    logic [TERM_W-1:0]  r_c, n_c;                      // chosen coefficient
    logic               r_semi, n_semi;
    logic [TERM_W-1:0]  r_p0n, n_p0n, r_p0d, n_p0d;
    logic [TERM_W-1:0]  r_p1n, n_p1n, r_p1d, n_p1d;
    logic [TERM_W-1:0]  r_pn, n_pn, r_pd, n_pd;
    logic [ACC_W-1:0]   r_w, n_w;
    logic               r_neg, n_neg;
    logic               r_ovalid, n_ovalid;
    logic [31:0]        r_onum, n_onum;
    logic [TERM_W-1:0]  r_oden, n_oden;
    logic               r_oexact, n_oexact;

    logic [IN_W-1:0]    in_num, in_den;
    logic [TERM_W-1:0]  xl, c_sel, pd_new;

    assign in_num = i_s_axis_tdata[IN_W-1:0];
    assign in_den = i_s_axis_tdata[2*IN_W-1:IN_W];
    assign o_s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        if (r_ninf) begin
            xl = r_limd;
        end else if (r_dinf) begin
            xl = r_limn;
        end else begin
            xl = (r_limn < r_limd) ? r_limn : r_limd;
        end
        c_sel  = (r_x > {{(IN_W-TERM_W){1'b0}}, xl}) ? xl : r_x[TERM_W-1:0];
        pd_new = r_acc[TERM_W-1:0] + r_p0d;
    end

    always_comb begin
        n_state  = r_state;
        n_num    = r_num;   n_den  = r_den;
        n_ea     = r_ea;    n_eb   = r_eb;
        n_x      = r_x;     n_rem  = r_rem;
        n_limn   = r_limn;  n_limd = r_limd;
        n_ninf   = r_ninf;  n_dinf = r_dinf;
        n_c      = r_c;     n_semi = r_semi;
        n_p0n    = r_p0n;   n_p0d  = r_p0d;
        n_p1n    = r_p1n;   n_p1d  = r_p1d;
        n_pn     = r_pn;    n_pd   = r_pd;
        n_w      = r_w;     n_neg  = r_neg;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        n_onum   = r_onum;  n_oden = r_oden; n_oexact = r_oexact;
        req      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_num   = in_num[IN_W-1] ? (IN_W'(0) - in_num) : in_num;
                    n_den   = in_den[IN_W-1] ? (IN_W'(0) - in_den) : in_den;
                    n_ea    = n_num;
                    n_eb    = n_den;
                    n_neg   = in_num[IN_W-1] ^ in_den[IN_W-1];
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (r_eb == '0) begin
                    if (r_ea != '0) begin
                        req     = '{start: 1'b1, mul: 1'b0, a: r_num, b: r_ea};
                        n_state = S_DIVN;
                    end else begin
                        n_state = S_CHK;
                    end
                end else begin
                    req     = '{start: 1'b1, mul: 1'b0, a: r_ea, b: r_eb};
                    n_state = S_GCDW;
                end
            end
            S_GCDW: begin
                if (!r_run) begin
                    n_ea    = r_eb;
                    n_eb    = r_ur;
                    n_state = S_GCD;
                end
            end
            S_DIVN: begin
                if (!r_run) begin
                    n_num   = r_uq;
                    req     = '{start: 1'b1, mul: 1'b0, a: r_den, b: r_ea};
                    n_state = S_DIVD;
                end
            end
            S_DIVD: begin
                if (!r_run) begin
                    n_den   = r_uq;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_num <= {{(IN_W-TERM_W){1'b0}}, lim} &&
                    r_den <= {{(IN_W-TERM_W){1'b0}}, lim}) begin
                    n_p1n   = r_num[TERM_W-1:0];
                    n_p1d   = r_den[TERM_W-1:0];
                    n_den   = '0;
                    n_state = S_OUT;
                end else begin
                    n_p0n   = '0;  n_p0d = TERM_W'(1);
                    n_p1n   = TERM_W'(1);  n_p1d = '0;
                    n_state = S_LOOP;
                end
            end
            S_LOOP: begin
                if (r_den == '0) begin
                    n_state = S_OUT;
                end else begin
                    req     = '{start: 1'b1, mul: 1'b0, a: r_num, b: r_den};
                    n_state = S_LX;
                end
            end
            S_LX: begin
                if (!r_run) begin
                    n_x     = r_uq;
                    n_rem   = r_ur;
                    n_state = S_LN0;
                end
            end
            S_LN0: begin
                if (r_p1n != '0) begin
                    req     = '{start: 1'b1, mul: 1'b0,
                                a: {{(IN_W-TERM_W){1'b0}}, lim - r_p0n},
                                b: {{(IN_W-TERM_W){1'b0}}, r_p1n}};
                    n_state = S_LN1;
                end else begin
                    n_ninf  = 1'b1;
                    n_state = S_LD0;
                end
            end
            S_LN1: begin
                if (!r_run) begin
                    n_limn  = r_uq[TERM_W-1:0];
                    n_ninf  = 1'b0;
                    n_state = S_LD0;
                end
            end
            S_LD0: begin
                if (r_p1d != '0) begin
                    req     = '{start: 1'b1, mul: 1'b0,
                                a: {{(IN_W-TERM_W){1'b0}}, lim - r_p0d},
                                b: {{(IN_W-TERM_W){1'b0}}, r_p1d}};
                    n_state = S_LD1;
                end else begin
                    n_dinf  = 1'b1;
                    n_state = S_SEL;
                end
            end
            S_LD1: begin
                if (!r_run) begin
                    n_limd  = r_uq[TERM_W-1:0];
                    n_dinf  = 1'b0;
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                n_semi  = (r_x > {{(IN_W-TERM_W){1'b0}}, xl});
                n_c     = c_sel;
                req     = '{start: 1'b1, mul: 1'b1,
                            a: {{(IN_W-TERM_W){1'b0}}, c_sel},
                            b: {{(IN_W-TERM_W){1'b0}}, r_p1n}};
                n_state = S_M1W;
            end
            S_M1W: begin
                if (!r_run) begin
                    n_pn    = r_acc[TERM_W-1:0] + r_p0n;
                    req     = '{start: 1'b1, mul: 1'b1,
                                a: {{(IN_W-TERM_W){1'b0}}, r_c},
                                b: {{(IN_W-TERM_W){1'b0}}, r_p1d}};
                    n_state = S_M2W;
                end
            end
            S_M2W: begin
                if (!r_run) begin
                    n_pd = pd_new;
                    if (r_semi) begin
                        // 2*c*p1d + p0d == 2*pd - p0d
                        n_state = S_M3W;
                        req     = '{start: 1'b1, mul: 1'b1, a: r_den,
                                    b: {{(IN_W-MULT_W){1'b0}},
                                        {pd_new, 1'b0} - {1'b0, r_p0d}}};
                    end else begin
                        n_p0n   = r_p1n;  n_p0d = r_p1d;
                        n_p1n   = r_pn;   n_p1d = pd_new;
                        n_num   = r_den;
                        n_den   = r_rem;
                        n_state = S_LOOP;
                    end
                end
            end
            S_M3W: begin
                if (!r_run) begin
                    n_w     = r_acc;
                    req     = '{start: 1'b1, mul: 1'b1, a: r_num,
                                b: {{(IN_W-TERM_W){1'b0}}, r_p1d}};
                    n_state = S_M4W;
                end
            end
            S_M4W: begin
                if (!r_run) begin
                    // semiconvergent wins when den*t > num*p1d
                    if (r_w > r_acc) begin
                        n_p1n = r_pn;
                        n_p1d = r_pd;
                    end
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_onum   = r_neg ? (32'd0 - {1'b0, r_p1n}) : {1'b0, r_p1n};
                    n_oden   = r_p1d;
                    n_oexact = (r_den == '0);
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num  <= n_num;   r_den  <= n_den;
        r_ea   <= n_ea;    r_eb   <= n_eb;
        r_x    <= n_x;     r_rem  <= n_rem;
        r_limn <= n_limn;  r_limd <= n_limd;
        r_ninf <= n_ninf;  r_dinf <= n_dinf;
        r_c    <= n_c;     r_semi <= n_semi;
        r_p0n  <= n_p0n;   r_p0d  <= n_p0d;
        r_p1n  <= n_p1n;   r_p1d  <= n_p1d;
        r_pn   <= n_pn;    r_pd   <= n_pd;
        r_w    <= n_w;     r_neg  <= n_neg;
        r_onum <= n_onum;  r_oden <= n_oden; r_oexact <= n_oexact;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {1'b0, r_oden, r_onum};
    assign o_m_axis_tuser  = r_oexact;

endmodule
